// ===== rtl/core/rip_pkg.sv =====
// Shared types and constants of the remote I/O polling master.
// Used by every module under rtl/core; depends on nothing else.
package rip_pkg;

    localparam int MAX_OUT_MODULES_DEF = 8;
    localparam int MAX_IN_MODULES_DEF  = 8;
    localparam int IMAGE_BITS_DEF      = 32;

    // Depths of the event queue and the result queue.
    localparam int EVQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_OUT_ENABLE    = 3'd0;
    localparam logic [2:0] REG_IN_ENABLE     = 3'd1;
    localparam logic [2:0] REG_OUT_COUNT     = 3'd2;
    localparam logic [2:0] REG_IN_COUNT      = 3'd3;
    localparam logic [2:0] REG_OUT_IDS       = 3'd4;
    localparam logic [2:0] REG_IN_IDS        = 3'd5;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd6;
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd7;

    localparam logic [3:0] FRAME_LEN_OUT = 4'd8;
    localparam logic [3:0] FRAME_LEN_IN  = 4'd0;

    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SEND_DONE = 2'd1,
        OP_FRAME     = 2'd2,
        OP_SET_IMAGE = 2'd3
    } t_op;

    typedef enum logic [5:0] {
        PH_ISSUE_OUT  = 6'b000001,
        PH_WSEND_OUT  = 6'b000010,
        PH_WREPLY_OUT = 6'b000100,
        PH_ISSUE_IN   = 6'b001000,
        PH_WSEND_IN   = 6'b010000,
        PH_WREPLY_IN  = 6'b100000
    } t_phase;

    typedef struct packed {
        t_op         op;
        logic [10:0] rx_id;
        logic [31:0] rx_data;
        logic [2:0]  module_select;
        logic [31:0] image_word;
    } t_event;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_id;
        logic [3:0]  tx_length;
        logic [31:0] tx_data;
        logic [2:0]  input_module;
        logic [31:0] input_word;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        out_enable;
        logic        in_enable;
        logic [3:0]  out_count;
        logic [3:0]  in_count;
        logic [63:0] out_ids;
        logic [63:0] in_ids;
        logic [15:0] timeout_ticks;
        logic [2:0]  retry_limit;
    } t_cfg;

endpackage

// ===== rtl/core/remote_io_poll_master.sv =====
// Remote I/O polling master: one bus event or image write is taken per cycle
// from push/full while full is low, and send requests and input image updates
// leave through empty/pop. The engine retires one event per clock whenever the
// result queue has two free slots, so the sustained rate is one item per cycle
// as long as the consumer pops one result per cycle; an item that yields two
// results (an input update followed by the next request) needs two pops, which
// the four-entry result queue and the two-entry event queue absorb. With both
// queues empty, an accepted item is held in the event queue and its first
// result is registered into the result queue at the next edge. Configuration
// registers are written through i_cfg_we, i_cfg_index and i_cfg_data and
// should only change while the block is idle.
module remote_io_poll_master
    import rip_pkg::*;
#(
    parameter int MAX_OUT_MODULES = MAX_OUT_MODULES_DEF,
    parameter int MAX_IN_MODULES  = MAX_IN_MODULES_DEF,
    parameter int IMAGE_BITS      = IMAGE_BITS_DEF
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   i_opcode,
    input  logic [10:0]  i_rx_id,
    input  logic [31:0]  i_rx_data,
    input  logic [2:0]   i_module_select,
    input  logic [31:0]  i_image_word,
    output logic         empty,
    input  logic         pop,
    output logic         o_kind,
    output logic [7:0]   o_tx_id,
    output logic [3:0]   o_tx_length,
    output logic [31:0]  o_tx_data,
    output logic [2:0]   o_input_module,
    output logic [31:0]  o_input_word,
    output logic         o_last,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    t_cfg     r_cfg;
    logic     ev_valid, ev_pop, room;
    t_event   ev;
    logic [1:0] wr_count;
    t_result  wr0, wr1, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_enable    <= 1'b1;
            r_cfg.in_enable     <= 1'b1;
            r_cfg.out_count     <= 4'd8;
            r_cfg.in_count      <= 4'd8;
            r_cfg.out_ids       <= '0;
            r_cfg.in_ids        <= '0;
            r_cfg.timeout_ticks <= 16'd20;
            r_cfg.retry_limit   <= 3'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUT_ENABLE:    r_cfg.out_enable    <= i_cfg_data[0];
                REG_IN_ENABLE:     r_cfg.in_enable     <= i_cfg_data[0];
                REG_OUT_COUNT:     r_cfg.out_count     <= i_cfg_data[3:0];
                REG_IN_COUNT:      r_cfg.in_count      <= i_cfg_data[3:0];
                REG_OUT_IDS:       r_cfg.out_ids       <= i_cfg_data;
                REG_IN_IDS:        r_cfg.in_ids        <= i_cfg_data;
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[15:0];
                REG_RETRY_LIMIT:   r_cfg.retry_limit   <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    rip_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_opcode        (i_opcode),
        .i_rx_id         (i_rx_id),
        .i_rx_data       (i_rx_data),
        .i_module_select (i_module_select),
        .i_image_word    (i_image_word),
        .o_full          (full),
        .o_ev_valid      (ev_valid),
        .o_ev            (ev),
        .i_ev_pop        (ev_pop)
    );

    rip_engine #(
        .MAX_OUT_MODULES (MAX_OUT_MODULES),
        .MAX_IN_MODULES  (MAX_IN_MODULES),
        .IMAGE_BITS      (IMAGE_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ev_valid (ev_valid),
        .i_ev       (ev),
        .o_ev_pop   (ev_pop),
        .i_room     (room),
        .o_wr_count (wr_count),
        .o_wr0      (wr0),
        .o_wr1      (wr1)
    );

    rip_res_queue u_res_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (wr_count),
        .i_wr0      (wr0),
        .i_wr1      (wr1),
        .o_room     (room),
        .o_empty    (empty),
        .o_head     (head),
        .i_pop      (pop)
    );

    assign o_kind         = head.kind;
    assign o_tx_id        = head.tx_id;
    assign o_tx_length    = head.tx_length;
    assign o_tx_data      = head.tx_data;
    assign o_input_module = head.input_module;
    assign o_input_word   = head.input_word;
    assign o_last         = head.last;

endmodule

// ===== rtl/core/rip_front.sv =====
// Front end of the polling master: takes bus events and image writes from the
// input side, decodes the opcode and holds them in a two-entry event queue.
// Depends on rip_pkg.
module rip_front
    import rip_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [1:0]   i_opcode,
    input  logic [10:0]  i_rx_id,
    input  logic [31:0]  i_rx_data,
    input  logic [2:0]   i_module_select,
    input  logic [31:0]  i_image_word,
    output logic         o_full,
    output logic         o_ev_valid,
    output t_event       o_ev,
    input  logic         i_ev_pop
);

    localparam int CW = $clog2(EVQ_DEPTH + 1);
    localparam int PW = $clog2(EVQ_DEPTH);

    t_event          r_mem [EVQ_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            wr_en, rd_en;
    t_event          ev_in;

    always_comb begin
        ev_in.op            = t_op'(i_opcode);
        ev_in.rx_id         = i_rx_id;
        ev_in.rx_data       = i_rx_data;
        ev_in.module_select = i_module_select;
        ev_in.image_word    = i_image_word;
    end

    assign o_full     = (r_count == CW'(EVQ_DEPTH));
    assign o_ev_valid = (r_count != '0);
    assign o_ev       = r_mem[r_rd_ptr];
    assign wr_en      = i_push && !o_full;
    assign rd_en      = i_ev_pop && o_ev_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(EVQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(EVQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= ev_in;
        end
    end

endmodule

// ===== rtl/core/rip_engine.sv =====
// Back end of the polling master: the phase sequencer, retry and timeout
// tracking, and the output image store. Takes one event a cycle while the
// result queue has room, and produces up to two results. Depends on rip_pkg.
module rip_engine
    import rip_pkg::*;
#(
    parameter int MAX_OUT_MODULES = MAX_OUT_MODULES_DEF,
    parameter int MAX_IN_MODULES  = MAX_IN_MODULES_DEF,
    parameter int IMAGE_BITS      = IMAGE_BITS_DEF
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_ev_valid,
    input  t_event       i_ev,
    output logic         o_ev_pop,
    input  logic         i_room,
    output logic [1:0]   o_wr_count,
    output t_result      o_wr0,
    output t_result      o_wr1
);

    t_phase                 r_phase, p1, p2;
    logic [2:0]             r_idx, idx1, idx2;
    logic [2:0]             r_retry, rt1;
    logic [15:0]            r_elapsed, el1;
    logic [IMAGE_BITS-1:0]  r_image [MAX_OUT_MODULES];

    logic        go;
    logic        outp, waitr;
    logic        do_fail, do_adv, upd;
    logic [2:0]  rt_inc;
    logic [3:0]  nx, cnt;
    logic [3:0]  eff_out, eff_in;
    logic [7:0]  reply_id;
    logic        send, send_out;
    logic [31:0] img_rd;
    t_result     res_upd, res_send;

    assign go       = i_ev_valid && i_room;
    assign o_ev_pop = go;

    always_comb begin
        // A count of zero means one module; a count above the maximum is clamped.
        if (i_cfg.out_count == 4'd0) begin
            eff_out = 4'd1;
        end else if (i_cfg.out_count > 4'(MAX_OUT_MODULES)) begin
            eff_out = 4'(MAX_OUT_MODULES);
        end else begin
            eff_out = i_cfg.out_count;
        end
        if (i_cfg.in_count == 4'd0) begin
            eff_in = 4'd1;
        end else if (i_cfg.in_count > 4'(MAX_IN_MODULES)) begin
            eff_in = 4'(MAX_IN_MODULES);
        end else begin
            eff_in = i_cfg.in_count;
        end
    end

    // Event handling: the waiting phases react to ticks, send-done and frames.
    always_comb begin
        p1       = r_phase;
        idx1     = r_idx;
        rt1      = r_retry;
        el1      = r_elapsed;
        do_fail  = 1'b0;
        do_adv   = 1'b0;
        upd      = 1'b0;
        outp     = (r_phase == PH_WREPLY_OUT);
        waitr    = outp || (r_phase == PH_WREPLY_IN);
        reply_id = outp ? i_cfg.out_ids[{r_idx, 3'b000} +: 8]
                        : i_cfg.in_ids[{r_idx, 3'b000} +: 8];
        rt_inc   = r_retry + 3'd1;
        nx       = {1'b0, r_idx} + 4'd1;
        cnt      = outp ? eff_out : eff_in;

        case (i_ev.op)
            OP_TICK: begin
                if (waitr) begin
                    if (r_elapsed != 16'hFFFF) begin
                        el1 = r_elapsed + 16'd1;
                    end
                    do_fail = (el1 >= i_cfg.timeout_ticks);
                end
            end
            OP_SEND_DONE: begin
                if (r_phase == PH_WSEND_OUT) begin
                    p1  = PH_WREPLY_OUT;
                    el1 = '0;
                end else if (r_phase == PH_WSEND_IN) begin
                    p1  = PH_WREPLY_IN;
                    el1 = '0;
                end
            end
            OP_FRAME: begin
                if (waitr) begin
                    if ({5'b00000, i_ev.rx_id[2:0]} == reply_id) begin
                        upd    = !outp;
                        do_adv = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_fail) begin
            if (rt_inc < i_cfg.retry_limit) begin
                rt1 = rt_inc;
                p1  = outp ? PH_ISSUE_OUT : PH_ISSUE_IN;
            end else begin
                do_adv = 1'b1;
            end
        end

        if (do_adv) begin
            rt1 = '0;
            if (nx < cnt) begin
                idx1 = nx[2:0];
                p1   = outp ? PH_ISSUE_OUT : PH_ISSUE_IN;
            end else begin
                idx1 = '0;
                p1   = outp ? PH_ISSUE_IN : PH_ISSUE_OUT;
            end
        end
    end

    // Request issue: a disabled phase hands over to the other one at module 0.
    always_comb begin
        p2       = p1;
        idx2     = idx1;
        send     = 1'b0;
        send_out = 1'b0;
        case (p1)
            PH_ISSUE_OUT: begin
                if (i_cfg.out_enable) begin
                    send     = 1'b1;
                    send_out = 1'b1;
                    p2       = PH_WSEND_OUT;
                end else if (i_cfg.in_enable) begin
                    idx2 = '0;
                    send = 1'b1;
                    p2   = PH_WSEND_IN;
                end else begin
                    idx2 = '0;
                    p2   = PH_ISSUE_OUT;
                end
            end
            PH_ISSUE_IN: begin
                if (i_cfg.in_enable) begin
                    send = 1'b1;
                    p2   = PH_WSEND_IN;
                end else if (i_cfg.out_enable) begin
                    idx2     = '0;
                    send     = 1'b1;
                    send_out = 1'b1;
                    p2       = PH_WSEND_OUT;
                end else begin
                    idx2 = '0;
                    p2   = PH_ISSUE_IN;
                end
            end
            default: begin
            end
        endcase
    end

    // Image read with the write of this same event forwarded.
    always_comb begin
        img_rd = '0;
        for (int k = 0; k < MAX_OUT_MODULES; k++) begin
            if (idx2 == 3'(k)) begin
                if (i_ev.op == OP_SET_IMAGE && i_ev.module_select == 3'(k)) begin
                    img_rd = 32'(i_ev.image_word[IMAGE_BITS-1:0]);
                end else begin
                    img_rd = 32'(r_image[k]);
                end
            end
        end
    end

    always_comb begin
        res_upd.kind         = KIND_UPDATE;
        res_upd.tx_id        = '0;
        res_upd.tx_length    = FRAME_LEN_IN;
        res_upd.tx_data      = '0;
        res_upd.input_module = r_idx;
        res_upd.input_word   = 32'(i_ev.rx_data[IMAGE_BITS-1:0]);
        res_upd.last         = !send;

        res_send.kind         = KIND_SEND;
        res_send.tx_id        = send_out ? i_cfg.out_ids[{idx2, 3'b000} +: 8]
                                         : i_cfg.in_ids[{idx2, 3'b000} +: 8];
        res_send.tx_length    = send_out ? FRAME_LEN_OUT : FRAME_LEN_IN;
        res_send.tx_data      = send_out ? img_rd : '0;
        res_send.input_module = '0;
        res_send.input_word   = '0;
        res_send.last         = 1'b1;

        o_wr0      = upd ? res_upd : res_send;
        o_wr1      = res_send;
        o_wr_count = go ? (2'(upd) + 2'(send)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ISSUE_OUT;
            r_idx     <= '0;
            r_retry   <= '0;
            r_elapsed <= '0;
        end else if (go) begin
            r_phase   <= p2;
            r_idx     <= idx2;
            r_retry   <= rt1;
            r_elapsed <= el1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_OUT_MODULES; k++) begin
                r_image[k] <= (k == 0) ? '1 : '0;
            end
        end else if (go && i_ev.op == OP_SET_IMAGE) begin
            for (int k = 0; k < MAX_OUT_MODULES; k++) begin
                if (i_ev.module_select == 3'(k)) begin
                    r_image[k] <= i_ev.image_word[IMAGE_BITS-1:0];
                end
            end
        end
    end

endmodule

// ===== rtl/core/rip_res_queue.sv =====
// Result queue of the polling master: takes up to two results a cycle from
// the engine and hands them out one at a time. Depends on rip_pkg.
module rip_res_queue
    import rip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_wr_count,
    input  t_result     i_wr0,
    input  t_result     i_wr1,
    output logic        o_room,
    output logic        o_empty,
    output t_result     o_head,
    input  logic        i_pop
);

    localparam int CW = $clog2(RESQ_DEPTH + 1);
    localparam int PW = $clog2(RESQ_DEPTH);

    t_result        r_mem [RESQ_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  wr_ptr1;
    logic           rd_en;

    // The engine only fires when two slots are free.
    assign o_room  = (r_count <= CW'(RESQ_DEPTH - 2));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign rd_en   = i_pop && !o_empty;
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_wr_count);
            r_rd_ptr <= r_rd_ptr + PW'(rd_en);
            r_count  <= r_count + CW'(i_wr_count) - CW'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[wr_ptr1] <= i_wr1;
        end
    end

endmodule
